// ===== src/dlfb_pkg.sv =====
// Package for the dense layer forward/backward block.
// Holds action and result codes, the queued command type and saturation helpers.
// No dependencies.
package dlfb_pkg;

  localparam int DefMaxInputs  = 64;
  localparam int DefMaxOutputs = 64;
  localparam int DefMaxBatch   = 8;
  localparam int CountLimit    = 64;
  localparam int QueueDepth    = 4;

  localparam logic [2:0] ACT_WR_WEIGHT = 3'd0;
  localparam logic [2:0] ACT_WR_BIAS   = 3'd1;
  localparam logic [2:0] ACT_FORWARD   = 3'd2;
  localparam logic [2:0] ACT_BACKWARD  = 3'd3;
  localparam logic [2:0] ACT_RD_WGRAD  = 3'd4;
  localparam logic [2:0] ACT_RD_BGRAD  = 3'd5;

  localparam logic [1:0] KIND_FORWARD = 2'd0;
  localparam logic [1:0] KIND_IN_GRAD = 2'd1;
  localparam logic [1:0] KIND_W_GRAD  = 2'd2;
  localparam logic [1:0] KIND_B_GRAD  = 2'd3;

  typedef struct packed {
    logic [2:0]         action;
    logic [5:0]         row;
    logic [5:0]         col;
    logic [2:0]         smp;
    logic signed [15:0] value;
    logic               first;
    logic               last;
  } cmd_t;

  function automatic int addr_width(input int n);
    return (n > 1) ? $clog2(n) : 1;
  endfunction

  function automatic logic signed [31:0] sat_add32(input logic signed [31:0] a,
                                                   input logic signed [31:0] b);
    logic signed [32:0] s;
    s = 33'(a) + 33'(b);
    if (s > 33'sh0_7FFF_FFFF) return 32'sh7FFF_FFFF;
    if (s < -33'sh0_8000_0000) return -32'sh8000_0000;
    return s[31:0];
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [24:0] v);
    if (v > 25'sd32767) return 16'sh7FFF;
    if (v < -25'sd32768) return -16'sh8000;
    return v[15:0];
  endfunction

endpackage

// ===== src/dlfb_front.sv =====
// Front end: accepts input items, drops ignored ones and queues commands.
// Depends on dlfb_pkg.
module dlfb_front #(
  parameter int MAX_INPUTS  = dlfb_pkg::DefMaxInputs,
  parameter int MAX_OUTPUTS = dlfb_pkg::DefMaxOutputs,
  parameter int MAX_BATCH   = dlfb_pkg::DefMaxBatch
) (
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [2:0]        in_tuser,
  input  logic [31:0]       in_tdata,
  input  logic [6:0]        nin,
  input  logic [6:0]        nout,
  input  logic              busy,
  input  logic              q_full,
  output logic              push,
  output dlfb_pkg::cmd_t    cmd
);
  import dlfb_pkg::*;

  logic keep;
  logic smp_ok;
  logic elem_last;

  assign in_tready = !q_full && !busy;

  assign cmd.action = in_tuser;
  assign cmd.row    = in_tdata[5:0];
  assign cmd.col    = in_tdata[11:6];
  assign cmd.smp    = in_tdata[14:12];
  assign cmd.value  = in_tdata[30:15];
  assign cmd.first  = in_tdata[31];
  assign cmd.last   = elem_last;

  assign smp_ok = int'(cmd.smp) < MAX_BATCH;

  always_comb begin
    keep      = 1'b0;
    elem_last = 1'b0;
    unique case (in_tuser) inside
      ACT_WR_WEIGHT: keep = int'(cmd.row) < MAX_OUTPUTS && int'(cmd.col) < MAX_INPUTS;
      ACT_WR_BIAS:   keep = int'(cmd.row) < MAX_OUTPUTS;
      ACT_FORWARD: begin
        keep      = smp_ok && ({1'b0, cmd.col} < nin);
        elem_last = ({1'b0, cmd.col} == nin - 7'd1);
      end
      ACT_BACKWARD: begin
        keep      = smp_ok && ({1'b0, cmd.col} < nout);
        elem_last = ({1'b0, cmd.col} == nout - 7'd1);
      end
      ACT_RD_WGRAD, ACT_RD_BGRAD: keep = 1'b1;
      default: keep = 1'b0;
    endcase
  end

  assign push = in_tvalid && in_tready && keep;

endmodule

// ===== src/dlfb_cmdq.sv =====
// Short command queue between the front end and the execution engine.
// Depends on dlfb_pkg.
module dlfb_cmdq (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  dlfb_pkg::cmd_t push_cmd,
  input  logic           pop,
  output logic           full,
  output logic           not_empty,
  output dlfb_pkg::cmd_t head
);
  import dlfb_pkg::*;

  localparam int PtrW = addr_width(QueueDepth);

  cmd_t            slot_r [QueueDepth];
  logic [PtrW-1:0] wr_ptr_r;
  logic [PtrW-1:0] rd_ptr_r;
  logic [PtrW:0]   count_r;

  assign full      = (count_r == (PtrW + 1)'(QueueDepth));
  assign not_empty = (count_r != '0);
  assign head      = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) slot_r[wr_ptr_r] <= push_cmd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= (int'(wr_ptr_r) == QueueDepth - 1) ? '0 : wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= (int'(rd_ptr_r) == QueueDepth - 1) ? '0 : rd_ptr_r + 1'b1;
      count_r <= count_r + (PtrW + 1)'(push) - (PtrW + 1)'(pop);
    end
  end

endmodule

// ===== src/dlfb_back.sv =====
// Execution engine: memories, one multiply-accumulate pipeline and the output register.
// Depends on dlfb_pkg.
module dlfb_back #(
  parameter int MAX_INPUTS  = dlfb_pkg::DefMaxInputs,
  parameter int MAX_OUTPUTS = dlfb_pkg::DefMaxOutputs,
  parameter int MAX_BATCH   = dlfb_pkg::DefMaxBatch
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic [6:0]     nin,
  input  logic [6:0]     nout,
  input  logic           bias_en,
  input  logic           q_not_empty,
  input  dlfb_pkg::cmd_t q_head,
  output logic           pop,
  output logic           init_busy,
  output logic           out_tvalid,
  input  logic           out_tready,
  output logic [1:0]     out_tuser,
  output logic [47:0]    out_tdata,
  output logic           out_tlast
);
  import dlfb_pkg::*;

  localparam int WDepth = MAX_OUTPUTS * MAX_INPUTS;
  localparam int CDepth = MAX_BATCH * MAX_INPUTS;
  localparam int WAW    = addr_width(WDepth);
  localparam int CAW    = addr_width(CDepth);
  localparam int BAW    = addr_width(MAX_OUTPUTS);

  localparam logic [3:0] S_CLR   = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_EXEC  = 4'd2;
  localparam logic [3:0] S_GB    = 4'd3;
  localparam logic [3:0] S_SCAN  = 4'd4;
  localparam logic [3:0] S_DRAIN = 4'd5;
  localparam logic [3:0] S_EMIT  = 4'd6;
  localparam logic [3:0] S_BGR   = 4'd7;
  localparam logic [3:0] S_BGW   = 4'd8;
  localparam logic [3:0] S_BCHK  = 4'd9;
  localparam logic [3:0] S_RD1   = 4'd10;
  localparam logic [3:0] S_RD2   = 4'd11;

  localparam logic [1:0] M_FWD = 2'd0;
  localparam logic [1:0] M_BWD = 2'd1;
  localparam logic [1:0] M_WGU = 2'd2;

  logic signed [15:0] w_mem  [WDepth];
  logic signed [15:0] b_mem  [MAX_OUTPUTS];
  logic signed [15:0] c_mem  [CDepth];
  logic signed [15:0] g_mem  [MAX_OUTPUTS];
  logic signed [31:0] wg_mem [WDepth];
  logic signed [31:0] bg_mem [MAX_OUTPUTS];

  logic signed [15:0] w_q, b_q, c_q, g_q;
  logic signed [31:0] wg_q, bg_q;

  logic [3:0]         state_r;
  logic [1:0]         mode_r;
  logic               clr_all_r;
  logic [WAW-1:0]     clr_cnt_r;
  cmd_t               cmd_r;
  logic [5:0]         outer_r;
  logic [5:0]         k_r;
  logic signed [31:0] acc_r;
  logic               p1_v_r, p2_v_r;
  logic [WAW-1:0]     wa1_r, wa2_r;
  logic signed [31:0] prod_r, wgh_r;

  logic               out_valid_r;
  logic [1:0]         kind_r;
  logic [5:0]         idx_r;
  logic [2:0]         smp_r;
  logic signed [31:0] res_r;
  logic               last_r;

  logic [6:0]         scan_len, outer_len;
  logic               k_last, outer_last, out_free, in_read, clr_bias_row;
  logic [WAW-1:0]     w_ra, w_wa, wg_ra, wg_wa;
  logic [CAW-1:0]     c_ra, c_wa;
  logic [BAW-1:0]     bg_ra, clr_row;
  logic signed [15:0] opa, opb;
  logic signed [31:0] mul_w, wg_wd, emit_val, rd_val;
  logic signed [24:0] ysum;
  logic               w_we, b_we, c_we, g_we, wg_we, bg_we;
  logic signed [15:0] b_wd;
  logic [BAW-1:0]     b_wa;
  logic signed [31:0] bg_wd;
  logic [BAW-1:0]     bg_wa;

  assign scan_len   = (mode_r == M_BWD) ? nout : nin;
  assign outer_len  = (mode_r == M_FWD) ? nout : nin;
  assign k_last     = ({1'b0, k_r} == scan_len - 7'd1);
  assign outer_last = ({1'b0, outer_r} == outer_len - 7'd1);
  assign out_free   = !out_valid_r || out_tready;
  assign in_read    = (state_r == S_RD1) || (state_r == S_RD2);
  assign clr_row    = BAW'(clr_cnt_r);
  assign clr_bias_row = (int'(clr_cnt_r) < MAX_OUTPUTS);

  // read addresses
  assign w_ra  = (mode_r == M_BWD) ? WAW'(int'(k_r) * MAX_INPUTS + int'(outer_r))
                                   : WAW'(int'(outer_r) * MAX_INPUTS + int'(k_r));
  assign c_ra  = CAW'(int'(cmd_r.smp) * MAX_INPUTS + int'(k_r));
  assign wg_ra = in_read ? WAW'(int'(cmd_r.row) * MAX_INPUTS + int'(cmd_r.col))
                         : WAW'(int'(cmd_r.col) * MAX_INPUTS + int'(k_r));
  assign bg_ra = in_read ? BAW'(cmd_r.row) : BAW'(cmd_r.col);

  // write ports
  assign w_we  = (state_r == S_EXEC) && (cmd_r.action == ACT_WR_WEIGHT);
  assign w_wa  = WAW'(int'(cmd_r.row) * MAX_INPUTS + int'(cmd_r.col));
  assign c_we  = (state_r == S_EXEC) && (cmd_r.action == ACT_FORWARD);
  assign c_wa  = CAW'(int'(cmd_r.smp) * MAX_INPUTS + int'(cmd_r.col));
  assign g_we  = (state_r == S_GB);
  assign b_we  = ((state_r == S_EXEC) && (cmd_r.action == ACT_WR_BIAS)) ||
                 ((state_r == S_CLR) && clr_all_r && clr_bias_row);
  assign b_wa  = (state_r == S_CLR) ? clr_row : BAW'(cmd_r.row);
  assign b_wd  = (state_r == S_CLR) ? 16'sd0 : cmd_r.value;
  assign wg_we = (state_r == S_CLR) || (p2_v_r && (mode_r == M_WGU));
  assign wg_wa = (state_r == S_CLR) ? clr_cnt_r : wa2_r;
  assign wg_wd = (state_r == S_CLR) ? 32'sd0 : sat_add32(wgh_r, prod_r);
  assign bg_we = ((state_r == S_CLR) && clr_bias_row) || (state_r == S_BGW);
  assign bg_wa = (state_r == S_CLR) ? clr_row : BAW'(cmd_r.col);
  assign bg_wd = (state_r == S_CLR) ? 32'sd0 : sat_add32(bg_q, 32'(cmd_r.value));

  always_ff @(posedge clk) begin
    if (w_we) w_mem[w_wa] <= cmd_r.value;
    w_q <= w_mem[w_ra];
  end
  always_ff @(posedge clk) begin
    if (b_we) b_mem[b_wa] <= b_wd;
    b_q <= b_mem[BAW'(outer_r)];
  end
  always_ff @(posedge clk) begin
    if (c_we) c_mem[c_wa] <= cmd_r.value;
    c_q <= c_mem[c_ra];
  end
  always_ff @(posedge clk) begin
    if (g_we) g_mem[BAW'(cmd_r.col)] <= cmd_r.value;
    g_q <= g_mem[BAW'(k_r)];
  end
  always_ff @(posedge clk) begin
    if (wg_we) wg_mem[wg_wa] <= wg_wd;
    wg_q <= wg_mem[wg_ra];
  end
  always_ff @(posedge clk) begin
    if (bg_we) bg_mem[bg_wa] <= bg_wd;
    bg_q <= bg_mem[bg_ra];
  end

  // multiplier operands
  assign opa   = (mode_r == M_WGU) ? cmd_r.value : w_q;
  assign opb   = (mode_r == M_BWD) ? g_q : c_q;
  assign mul_w = 32'(opa) * 32'(opb);

  assign ysum = 25'(acc_r >>> 8) +
                (((mode_r == M_FWD) && bias_en) ? 25'(b_q) : 25'sd0);
  assign emit_val = 32'(sat16(ysum));

  always_comb begin
    rd_val = 32'sd0;
    if (cmd_r.action == ACT_RD_WGRAD) begin
      if (int'(cmd_r.row) < MAX_OUTPUTS && int'(cmd_r.col) < MAX_INPUTS) rd_val = wg_q;
    end else begin
      if (int'(cmd_r.row) < MAX_OUTPUTS) rd_val = bg_q;
    end
  end

  assign pop       = (state_r == S_IDLE) && q_not_empty;
  assign init_busy = (state_r == S_CLR) && clr_all_r;

  // MAC pipeline: read, multiply, accumulate or write back
  always_ff @(posedge clk) begin
    wa1_r  <= wg_ra;
    wa2_r  <= wa1_r;
    prod_r <= mul_w;
    wgh_r  <= wg_q;
    // hold the sum while a result waits for room
    if ((state_r == S_EMIT && out_free) || state_r == S_BCHK || state_r == S_EXEC)
      acc_r <= 32'sd0;
    if (p2_v_r && mode_r != M_WGU) acc_r <= sat_add32(acc_r, prod_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_all_r   <= 1'b1;
      clr_cnt_r   <= '0;
      mode_r      <= M_FWD;
      outer_r     <= '0;
      k_r         <= '0;
      p1_v_r      <= 1'b0;
      p2_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      p1_v_r <= (state_r == S_SCAN);
      p2_v_r <= p1_v_r;
      if (out_valid_r && out_tready) out_valid_r <= 1'b0;

      unique case (state_r)
        S_CLR: begin
          clr_cnt_r <= clr_cnt_r + 1'b1;
          if (int'(clr_cnt_r) == WDepth - 1) begin
            clr_cnt_r <= '0;
            state_r   <= clr_all_r ? S_IDLE : S_GB;
          end
        end
        S_IDLE: begin
          if (q_not_empty) begin
            cmd_r   <= q_head;
            state_r <= S_EXEC;
          end
        end
        S_EXEC: begin
          outer_r <= '0;
          k_r     <= '0;
          unique case (cmd_r.action) inside
            ACT_FORWARD: begin
              mode_r  <= M_FWD;
              state_r <= cmd_r.last ? S_SCAN : S_IDLE;
            end
            ACT_BACKWARD: begin
              if (cmd_r.first) begin
                clr_all_r <= 1'b0;
                clr_cnt_r <= '0;
                state_r   <= S_CLR;
              end else begin
                state_r <= S_GB;
              end
            end
            ACT_RD_WGRAD, ACT_RD_BGRAD: state_r <= S_RD1;
            default: state_r <= S_IDLE;
          endcase
        end
        S_GB: begin
          mode_r  <= M_WGU;
          k_r     <= '0;
          state_r <= S_SCAN;
        end
        S_SCAN: begin
          k_r <= k_r + 1'b1;
          if (k_last) state_r <= S_DRAIN;
        end
        S_DRAIN: begin
          if (!p1_v_r && !p2_v_r) begin
            if (mode_r == M_WGU) state_r <= bias_en ? S_BGR : S_BCHK;
            else                 state_r <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            kind_r      <= (mode_r == M_FWD) ? KIND_FORWARD : KIND_IN_GRAD;
            idx_r       <= outer_r;
            smp_r       <= cmd_r.smp;
            res_r       <= emit_val;
            last_r      <= outer_last;
            k_r         <= '0;
            outer_r     <= outer_r + 1'b1;
            state_r     <= outer_last ? S_IDLE : S_SCAN;
          end
        end
        S_BGR: state_r <= S_BGW;
        S_BGW: state_r <= S_BCHK;
        S_BCHK: begin
          mode_r  <= M_BWD;
          outer_r <= '0;
          k_r     <= '0;
          state_r <= cmd_r.last ? S_SCAN : S_IDLE;
        end
        S_RD1: state_r <= S_RD2;
        S_RD2: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            kind_r      <= (cmd_r.action == ACT_RD_WGRAD) ? KIND_W_GRAD : KIND_B_GRAD;
            idx_r       <= (cmd_r.action == ACT_RD_WGRAD) ? cmd_r.col : cmd_r.row;
            smp_r       <= 3'd0;
            res_r       <= rd_val;
            last_r      <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = kind_r;
  assign out_tdata  = {7'd0, res_r, smp_r, idx_r};
  assign out_tlast  = last_r;

  a_no_pop_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLR) |-> !pop) else $error("command taken during clearing sweep");

  a_pipe_order: assert property (@(posedge clk) disable iff (!rst_n)
    p2_v_r |-> $past(p1_v_r)) else $error("MAC pipeline stage out of order");

  a_emit_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EMIT && out_valid_r && !out_tready) |=> (state_r == S_EMIT))
    else $error("result loaded over a pending one");

endmodule

// ===== src/dense_layer_forward_backward.sv =====
// Dense layer forward/backward block, top level.
// Holds the APB register file and ties front end, command queue and engine.
// Depends on dlfb_pkg, dlfb_front, dlfb_cmdq, dlfb_back.
//
// Fully connected layer in Q8.8 with saturating 32-bit accumulation. Items enter
// on the in_ stream; the front end drops ignored items and queues the rest, and
// the engine executes them one at a time with a single multiply-accumulate unit
// fed from registered-read memories. The last forward element computes every
// output, one MAC per cycle against the weight memory while a row is scanned;
// each backward element runs the weight-gradient update (and the bias-gradient
// update with bias on), and the last one then computes the input gradient. A
// backward element with batch_first set first sweeps the gradient stores, one
// entry per cycle. After reset the same sweep also clears the bias store;
// in_tready stays low during that sweep, while configuration writes are taken
// as usual. Results sit in an output register, so the engine keeps going while
// the next one waits.
module dense_layer_forward_backward #(
  parameter int MAX_INPUTS  = dlfb_pkg::DefMaxInputs,
  parameter int MAX_OUTPUTS = dlfb_pkg::DefMaxOutputs,
  parameter int MAX_BATCH   = dlfb_pkg::DefMaxBatch
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [2:0]  in_tuser,   // action
  input  logic [31:0] in_tdata,   // row[5:0], column[11:6], sample[14:12], value[30:15],
                                  // batch_first[31]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [1:0]  out_tuser,  // kind
  output logic [47:0] out_tdata,  // index[5:0], sample_out[8:6], result_value[40:9], zero pad
  output logic        out_tlast,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import dlfb_pkg::*;

  localparam logic [1:0] REG_INPUT_COUNT  = 2'd0;
  localparam logic [1:0] REG_OUTPUT_COUNT = 2'd1;
  localparam logic [1:0] REG_BIAS_ENABLE  = 2'd2;

  localparam int LimIn  = (MAX_INPUTS < CountLimit) ? MAX_INPUTS : CountLimit;
  localparam int LimOut = (MAX_OUTPUTS < CountLimit) ? MAX_OUTPUTS : CountLimit;

  logic [6:0] input_count_r;
  logic [6:0] output_count_r;
  logic       bias_enable_r;
  logic [6:0] nin, nout;
  logic       cfg_wr;

  logic       push, pop, q_full, q_not_empty, init_busy;
  cmd_t       push_cmd, q_head;

  // APB register file: always ready, write on the access phase
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      input_count_r  <= 7'd64;
      output_count_r <= 7'd64;
      bias_enable_r  <= 1'b1;
    end else if (cfg_wr) begin
      unique case (cfg_paddr[3:2])
        REG_INPUT_COUNT:  input_count_r  <= cfg_pwdata[6:0];
        REG_OUTPUT_COUNT: output_count_r <= cfg_pwdata[6:0];
        REG_BIAS_ENABLE:  bias_enable_r  <= cfg_pwdata[0];
        default: ;  // unmapped register, drop the write
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[3:2])
      REG_INPUT_COUNT:  cfg_prdata = {25'd0, input_count_r};
      REG_OUTPUT_COUNT: cfg_prdata = {25'd0, output_count_r};
      REG_BIAS_ENABLE:  cfg_prdata = {31'd0, bias_enable_r};
      default:          cfg_prdata = 32'd0;
    endcase
  end

  // Clamp the counts to the range the memories hold
  assign nin  = (input_count_r == 7'd0) ? 7'd1 :
                (int'(input_count_r) > LimIn) ? 7'(LimIn) : input_count_r;
  assign nout = (output_count_r == 7'd0) ? 7'd1 :
                (int'(output_count_r) > LimOut) ? 7'(LimOut) : output_count_r;

  dlfb_front #(
    .MAX_INPUTS (MAX_INPUTS),
    .MAX_OUTPUTS(MAX_OUTPUTS),
    .MAX_BATCH  (MAX_BATCH)
  ) u_front (
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tuser (in_tuser),
    .in_tdata (in_tdata),
    .nin      (nin),
    .nout     (nout),
    .busy     (init_busy),
    .q_full   (q_full),
    .push     (push),
    .cmd      (push_cmd)
  );

  dlfb_cmdq u_cmdq (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .full     (q_full),
    .not_empty(q_not_empty),
    .head     (q_head)
  );

  dlfb_back #(
    .MAX_INPUTS (MAX_INPUTS),
    .MAX_OUTPUTS(MAX_OUTPUTS),
    .MAX_BATCH  (MAX_BATCH)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .nin        (nin),
    .nout       (nout),
    .bias_en    (bias_enable_r),
    .q_not_empty(q_not_empty),
    .q_head     (q_head),
    .pop        (pop),
    .init_busy  (init_busy),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tuser  (out_tuser),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule
